// ===== rtl/slskc_pkg.sv =====
`default_nettype none

package slskc_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int LOG_TABLE_BITS_DEF = 8;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RED_W     = 14;
    localparam int COMB_W    = 33;

    localparam int DIV_DVD_W = 43;
    localparam int DIV_DVS_W = 31;
    localparam int DIV_Q_W   = 17;
    localparam int DIV_CNT_W = 5;

    localparam int DIV_SLOPE_ITERS = 17;
    localparam int DIV_KNEE_ITERS  = 12;

    localparam int RED_MAX      = 15360;
    localparam int AUTO_REL_MIN = 1536;
    localparam int SILENCE_DB   = 32768;
    localparam int DB_SCALE     = 394566;
    localparam int EXP_SCALE    = 10885;
    localparam int METER_KEEP   = 58982;
    localparam int METER_NEW    = 6554;

    localparam logic [14:0] THRESHOLD_RST = 15'd27648;
    localparam logic [12:0] RATIO_RST     = 13'd1024;
    localparam logic [11:0] KNEE_RST      = 12'd0;
    localparam logic [15:0] ATTACK_RST    = 16'd6554;
    localparam logic [15:0] RELEASE_RST   = 16'd66;
    localparam logic [15:0] SLOW_REL_RST  = 16'd33;
    localparam logic [15:0] MAKEUP_RST    = 16'd4096;
    localparam logic [1:0]  MODE_RST      = 2'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 3'd0,
        CFG_RATIO        = 3'd1,
        CFG_KNEE         = 3'd2,
        CFG_ATTACK       = 3'd3,
        CFG_RELEASE      = 3'd4,
        CFG_SLOW_RELEASE = 3'd5,
        CFG_MAKEUP       = 3'd6,
        CFG_MODE         = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_ENV, OP_LZ, OP_DB, OP_MAG, OP_SLOPE_GO, OP_GC1, OP_GC2,
        OP_KNEE_GO, OP_GFIN, OP_AREL, OP_EXP0, OP_EXPI, OP_GQ, OP_COMB, OP_SCL,
        OP_SCR, OP_SATR, OP_MET1, OP_MET2, OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_take;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic last;
        logic lz_done;
        logic div_busy;
        logic soft_mid;
        logic exp_last;
    } t_status;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] log_entry(input int idx, input int lb);
        logic [63:0] m;
        logic [15:0] r;
        m = (64'd1 << lb) + 64'(idx);
        m = m << (30 - lb);
        r = 16'd0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = {r[14:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                r[0] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [30:0] exp_root(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int j = 1; j < 16; j++) begin
            if (j <= k) r = isqrt64(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slskc_div.sv =====
`default_nettype none

module slskc_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [slskc_pkg::DIV_DVD_W-1:0]     i_dividend,
    input  wire logic [slskc_pkg::DIV_DVS_W-1:0]     i_divisor,
    input  wire logic [slskc_pkg::DIV_CNT_W-1:0]     i_iters,
    output logic      [slskc_pkg::DIV_Q_W-1:0]       o_quot,
    output logic                                     o_busy
);

    localparam int DW = slskc_pkg::DIV_DVD_W;
    localparam int SW = slskc_pkg::DIV_DVS_W;
    localparam int QW = slskc_pkg::DIV_Q_W;
    localparam int CW = slskc_pkg::DIV_CNT_W;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [SW:0]   r_rem;
    logic [DW-1:0] r_sh;
    logic [SW-1:0] r_div;
    logic [QW-1:0] r_q;
    logic [SW:0]   trial;
    logic          fits;
    logic [DW-1:0] shifted_down;

    assign trial        = {r_rem[SW-1:0], r_sh[DW-1]};
    assign fits         = trial >= {1'b0, r_div};
    assign shifted_down = i_dividend >> i_iters;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= i_iters != '0;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_busy <= r_cnt != CW'(1);
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= shifted_down[SW:0];
            r_sh  <= i_dividend << (DW - int'(i_iters));
            r_div <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, r_div} : trial;
            r_sh  <= r_sh << 1;
            r_q   <= {r_q[QW-2:0], fits};
        end
    end

    assign o_quot = r_q;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== rtl/slskc_ctrl.sv =====
`default_nettype none

module slskc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    input  wire slskc_pkg::t_status   i_st,
    output slskc_pkg::t_cmd           o_cmd
);

    typedef enum logic [22:0] {
        S_IDLE = 23'h1,
        S_ENV  = 23'h1 << 1,
        S_LZ   = 23'h1 << 2,
        S_DB   = 23'h1 << 3,
        S_MAG  = 23'h1 << 4,
        S_SLG  = 23'h1 << 5,
        S_SLW  = 23'h1 << 6,
        S_GC1  = 23'h1 << 7,
        S_GC2  = 23'h1 << 8,
        S_KDG  = 23'h1 << 9,
        S_KDW  = 23'h1 << 10,
        S_GFIN = 23'h1 << 11,
        S_AREL = 23'h1 << 12,
        S_EXP0 = 23'h1 << 13,
        S_EXPI = 23'h1 << 14,
        S_GQ   = 23'h1 << 15,
        S_COMB = 23'h1 << 16,
        S_SCL  = 23'h1 << 17,
        S_SCR  = 23'h1 << 18,
        S_SATR = 23'h1 << 19,
        S_MET1 = 23'h1 << 20,
        S_MET2 = 23'h1 << 21,
        S_FIN  = 23'h1 << 22
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;
    logic   take;

    assign take = !r_ovalid || i_ready;

    always_comb begin
        n_state        = r_state;
        n_ovalid       = r_ovalid && !i_ready;
        o_cmd.op       = slskc_pkg::OP_NOP;
        o_cmd.out_take = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = slskc_pkg::OP_LOAD;
                    n_state  = i_st.bypass ? S_FIN : S_ENV;
                end
            end
            S_ENV: begin
                o_cmd.op = slskc_pkg::OP_ENV;
                n_state  = S_LZ;
            end
            S_LZ: begin
                o_cmd.op = slskc_pkg::OP_LZ;
                if (i_st.lz_done) n_state = S_DB;
            end
            S_DB: begin
                o_cmd.op = slskc_pkg::OP_DB;
                n_state  = S_MAG;
            end
            S_MAG: begin
                o_cmd.op = slskc_pkg::OP_MAG;
                n_state  = S_SLG;
            end
            S_SLG: begin
                o_cmd.op = slskc_pkg::OP_SLOPE_GO;
                n_state  = S_SLW;
            end
            S_SLW: begin
                if (!i_st.div_busy) n_state = S_GC1;
            end
            S_GC1: begin
                o_cmd.op = slskc_pkg::OP_GC1;
                n_state  = S_GC2;
            end
            S_GC2: begin
                o_cmd.op = slskc_pkg::OP_GC2;
                n_state  = i_st.soft_mid ? S_KDG : S_GFIN;
            end
            S_KDG: begin
                o_cmd.op = slskc_pkg::OP_KNEE_GO;
                n_state  = S_KDW;
            end
            S_KDW: begin
                if (!i_st.div_busy) n_state = S_GFIN;
            end
            S_GFIN: begin
                o_cmd.op = slskc_pkg::OP_GFIN;
                n_state  = S_AREL;
            end
            S_AREL: begin
                o_cmd.op = slskc_pkg::OP_AREL;
                n_state  = S_EXP0;
            end
            S_EXP0: begin
                o_cmd.op = slskc_pkg::OP_EXP0;
                n_state  = S_EXPI;
            end
            S_EXPI: begin
                o_cmd.op = slskc_pkg::OP_EXPI;
                if (i_st.exp_last) n_state = S_GQ;
            end
            S_GQ: begin
                o_cmd.op = slskc_pkg::OP_GQ;
                n_state  = S_COMB;
            end
            S_COMB: begin
                o_cmd.op = slskc_pkg::OP_COMB;
                n_state  = S_SCL;
            end
            S_SCL: begin
                o_cmd.op = slskc_pkg::OP_SCL;
                n_state  = S_SCR;
            end
            S_SCR: begin
                o_cmd.op = slskc_pkg::OP_SCR;
                n_state  = S_SATR;
            end
            S_SATR: begin
                o_cmd.op = slskc_pkg::OP_SATR;
                n_state  = i_st.last ? S_MET1 : S_FIN;
            end
            S_MET1: begin
                o_cmd.op = slskc_pkg::OP_MET1;
                n_state  = S_MET2;
            end
            S_MET2: begin
                o_cmd.op = slskc_pkg::OP_MET2;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (take) begin
                    o_cmd.op       = slskc_pkg::OP_OUT;
                    o_cmd.out_take = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_ovalid;

`ifndef NO_ASSERTIONS
    a_bypass_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_st.bypass) |=> r_state == S_FIN)
        else $error("bypass transaction did not go straight to output");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLW && !i_st.div_busy) |=> r_state == S_GC1)
        else $error("slope division wait did not release");
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_ovalid) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished result not loaded into empty output");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("output became valid outside the finish step");
`endif

endmodule

`default_nettype wire

// ===== rtl/slskc_dp.sv =====
`default_nettype none

module slskc_dp #(
    parameter int SAMPLE_BITS    = slskc_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_BITS = slskc_pkg::LOG_TABLE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [slskc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [slskc_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_right_sample,
    input  wire logic                                i_mono,
    input  wire logic                                i_block_end,
    input  wire slskc_pkg::t_cmd                     i_cmd,
    output slskc_pkg::t_status                       o_st,
    output logic signed [SAMPLE_BITS-1:0]            o_left_out,
    output logic signed [SAMPLE_BITS-1:0]            o_right_out,
    output logic [slskc_pkg::RED_W-1:0]              o_reduction_db,
    output logic [slskc_pkg::RED_W-1:0]              o_meter_db
);

    localparam int SB     = SAMPLE_BITS;
    localparam int LB     = LOG_TABLE_BITS;
    localparam int LT     = 1 << LB;
    localparam int PW     = $clog2(SB);
    localparam int DEF_W  = PW + 16;
    localparam int MAGP_W = DEF_W + 19;
    localparam int JW     = (LB > 1) ? $clog2(LB) : 1;
    localparam int PROD_W = SB + slskc_pkg::COMB_W;
    localparam int RW     = slskc_pkg::RED_W;
    localparam int DW     = slskc_pkg::DIV_DVD_W;
    localparam int SW     = slskc_pkg::DIV_DVS_W;
    localparam int QW     = slskc_pkg::DIV_Q_W;

    typedef enum logic [1:0] {G_ZERO, G_HARD, G_SOFT} t_gsel;

    logic [15:0] log_rom [LT];
    logic [30:0] root_rom [LB];

    for (genvar gi = 0; gi < LT; gi++) begin : g_log
        assign log_rom[gi] = slskc_pkg::log_entry(gi, LB);
    end
    for (genvar gk = 0; gk < LB; gk++) begin : g_root
        assign root_rom[gk] = slskc_pkg::exp_root(gk);
    end

    logic [14:0] r_thr;
    logic [12:0] r_ratio;
    logic [11:0] r_knee;
    logic [15:0] r_att;
    logic [15:0] r_rel;
    logic [15:0] r_slow;
    logic [15:0] r_mkp;
    logic [1:0]  r_mode;

    logic [SB-1:0] r_env;
    logic [SB-1:0] n_env;
    logic [RW-1:0] r_peak;
    logic [RW-1:0] r_sm;

    logic [SB-1:0]     r_lraw;
    logic [SB-1:0]     r_rraw;
    logic [SB-1:0]     r_lmag;
    logic [SB-1:0]     r_rmag;
    logic              r_lneg;
    logic              r_rneg;
    logic              r_mono;
    logic              r_last;
    logic              r_byp;
    logic [SB-1:0]     r_level;
    logic [SB-1:0]     r_norm;
    logic [PW-1:0]     r_p;
    logic [DEF_W-1:0]  r_def;
    logic              r_zero;
    logic signed [16:0] r_x;
    logic [16:0]       r_slope;
    logic [DW-1:0]     r_gp;
    t_gsel             r_gsel;
    logic [RW-1:0]     r_red;
    logic [3:0]        r_n;
    logic [LB-1:0]     r_top;
    logic [30:0]       r_g;
    logic [JW-1:0]     r_j;
    logic [16:0]       r_gq;
    logic [slskc_pkg::COMB_W-1:0] r_comb;
    logic [PROD_W-1:0] r_prod;
    logic [SB-1:0]     r_lo;
    logic [SB-1:0]     r_ro;
    logic [29:0]       r_macc;
    logic [SB-1:0]     r_out_l;
    logic [SB-1:0]     r_out_r;
    logic [RW-1:0]     r_out_red;
    logic [RW-1:0]     r_out_met;

    slskc_pkg::t_op op;
    assign op = i_cmd.op;

    // Input magnitudes.
    logic [SB-1:0] in_r;
    logic [SB-1:0] in_lmag;
    logic [SB-1:0] in_rmag;
    assign in_r    = i_mono ? i_left_sample : i_right_sample;
    assign in_lmag = i_left_sample[SB-1] ? (~i_left_sample + SB'(1)) : i_left_sample;
    assign in_rmag = in_r[SB-1] ? (~in_r + SB'(1)) : in_r;

    // Envelope follower.
    logic              env_up;
    logic [SB-1:0]     env_diff;
    logic [15:0]       env_coef;
    logic [SB+15:0]    env_prod;
    logic [SB-1:0]     env_att;
    assign env_up   = r_level > r_env;
    assign env_diff = env_up ? r_level - r_env : r_env - r_level;
    assign env_coef = env_up ? r_att : r_rel;
    assign env_prod = (SB+16)'(env_coef) * (SB+16)'(env_diff);
    assign env_att  = env_up ? r_env + env_prod[SB+15:16] : r_env - env_prod[SB+15:16];

    // Auto release nudge.
    logic           ar_on;
    logic           ar_dpos;
    logic           ar_fpos;
    logic [15:0]    ar_dmag;
    logic [SB-1:0]  ar_fmag;
    logic [SB+15:0] ar_prod;
    logic [SB-1:0]  ar_step;
    logic [SB:0]    ar_sum;
    logic [SB-1:0]  ar_env;
    assign ar_on   = r_mode[1] && (r_red > RW'(slskc_pkg::AUTO_REL_MIN));
    assign ar_dpos = r_slow >= r_rel;
    assign ar_dmag = ar_dpos ? r_slow - r_rel : r_rel - r_slow;
    assign ar_fpos = r_level >= r_env;
    assign ar_fmag = ar_fpos ? r_level - r_env : r_env - r_level;
    assign ar_prod = (SB+16)'(ar_dmag) * (SB+16)'(ar_fmag);
    assign ar_step = {1'b0, ar_prod[SB+15:17]};
    assign ar_sum  = {1'b0, r_env} + {1'b0, ar_step};

    always_comb begin
        if (ar_dpos == ar_fpos) begin
            ar_env = (ar_sum > ((SB+1)'(1) << (SB-1))) ? (SB'(1) << (SB-1)) : ar_sum[SB-1:0];
        end else begin
            ar_env = (ar_step > r_env) ? '0 : r_env - ar_step;
        end
    end

    always_comb begin
        case (op)
            slskc_pkg::OP_ENV:  n_env = env_att;
            slskc_pkg::OP_AREL: n_env = ar_on ? ar_env : r_env;
            default:            n_env = r_env;
        endcase
    end

    // Level in dB.
    logic [LB-1:0]     lz_idx;
    logic [DEF_W-1:0]  db_l2;
    logic [DEF_W-1:0]  db_full;
    logic [MAGP_W-1:0] mag_prod;
    logic [MAGP_W-1:0] mag_sh;
    logic [16:0]       mag_c;
    assign lz_idx   = r_norm[SB-2 -: LB];
    assign db_l2    = {r_p, log_rom[lz_idx]};
    assign db_full  = DEF_W'(SB - 1) << 16;
    assign mag_prod = MAGP_W'(r_def) * MAGP_W'(slskc_pkg::DB_SCALE);
    assign mag_sh   = mag_prod >> 24;
    assign mag_c    = (r_zero || mag_sh > MAGP_W'(slskc_pkg::SILENCE_DB))
                      ? 17'(slskc_pkg::SILENCE_DB) : mag_sh[16:0];

    // Divider.
    logic          div_start;
    logic [DW-1:0] div_dvd;
    logic [SW-1:0] div_dvs;
    logic [slskc_pkg::DIV_CNT_W-1:0] div_iters;
    logic [QW-1:0] div_q;
    logic          div_busy;
    logic [12:0]   ratio_c;

    assign ratio_c   = (r_ratio < 13'd256) ? 13'd256 : r_ratio;
    assign div_start = (op == slskc_pkg::OP_SLOPE_GO) || (op == slskc_pkg::OP_KNEE_GO);

    always_comb begin
        if (op == slskc_pkg::OP_KNEE_GO) begin
            div_dvd   = r_gp;
            div_dvs   = {r_knee, 19'd0};
            div_iters = slskc_pkg::DIV_CNT_W'(slskc_pkg::DIV_KNEE_ITERS);
        end else begin
            div_dvd   = DW'(1) << 24;
            div_dvs   = SW'(ratio_c);
            div_iters = slskc_pkg::DIV_CNT_W'(slskc_pkg::DIV_SLOPE_ITERS);
        end
    end

    slskc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_iters    (div_iters),
        .o_quot     (div_q),
        .o_busy     (div_busy)
    );

    // Gain computer.
    logic [16:0]        slope_now;
    logic signed [17:0] t18;
    logic signed [17:0] w18;
    logic signed [17:0] x18;
    logic signed [17:0] xs;
    logic signed [17:0] ks;
    logic signed [17:0] ke;
    logic signed [17:0] xmt;
    logic signed [17:0] u18;
    logic [26:0]        red_full;
    logic [RW-1:0]      n_red;

    assign slope_now = 17'h10000 - div_q;
    assign t18 = {{3{r_thr[14]}}, r_thr};
    assign w18 = {6'd0, r_knee};
    assign x18 = {r_x[16], r_x};
    assign xs  = x18 <<< 1;
    assign ks  = (t18 <<< 1) - w18;
    assign ke  = (t18 <<< 1) + w18;
    assign xmt = x18 - t18;
    assign u18 = xs - ks;

    always_comb begin
        case (r_gsel)
            G_HARD:  red_full = r_gp[42:16];
            G_SOFT:  red_full = 27'(div_q);
            default: red_full = '0;
        endcase
        n_red = (red_full > 27'(slskc_pkg::RED_MAX)) ? RW'(slskc_pkg::RED_MAX) : red_full[RW-1:0];
    end

    // Reduction gain and scaling.
    logic [27:0] e_prod;
    logic [61:0] g_prod;
    logic [30:0] g_sh;
    logic [31:0] g_rnd;
    assign e_prod = 28'(r_red) * 28'(slskc_pkg::EXP_SCALE);
    assign g_prod = 62'(r_g) * 62'(root_rom[r_j]) + (62'(1) << 29);
    assign g_sh   = r_g >> r_n;
    assign g_rnd  = {1'b0, g_sh} + (32'(1) << 13);

    logic [30:0] met_sum;
    assign met_sum = 31'(r_macc) + 31'(r_peak) * 31'(slskc_pkg::METER_NEW) + 31'(32768);

    function automatic logic [SB-1:0] sat_round(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W-1:0] y;
        y = (p + (PROD_W'(1) << 27)) >> 28;
        if (neg) begin
            if (y > (PROD_W'(1) << (SB-1))) y = PROD_W'(1) << (SB-1);
            return SB'(0) - y[SB-1:0];
        end
        if (y > ((PROD_W'(1) << (SB-1)) - PROD_W'(1))) y = (PROD_W'(1) << (SB-1)) - PROD_W'(1);
        return y[SB-1:0];
    endfunction

    // State with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= slskc_pkg::THRESHOLD_RST;
            r_ratio <= slskc_pkg::RATIO_RST;
            r_knee  <= slskc_pkg::KNEE_RST;
            r_att   <= slskc_pkg::ATTACK_RST;
            r_rel   <= slskc_pkg::RELEASE_RST;
            r_slow  <= slskc_pkg::SLOW_REL_RST;
            r_mkp   <= slskc_pkg::MAKEUP_RST;
            r_mode  <= slskc_pkg::MODE_RST;
            r_env   <= '0;
            r_peak  <= '0;
            r_sm    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (slskc_pkg::t_cfg_idx'(i_cfg_idx))
                    slskc_pkg::CFG_THRESHOLD:    r_thr   <= i_cfg_data[14:0];
                    slskc_pkg::CFG_RATIO:        r_ratio <= i_cfg_data[12:0];
                    slskc_pkg::CFG_KNEE:         r_knee  <= i_cfg_data[11:0];
                    slskc_pkg::CFG_ATTACK:       r_att   <= i_cfg_data;
                    slskc_pkg::CFG_RELEASE:      r_rel   <= i_cfg_data;
                    slskc_pkg::CFG_SLOW_RELEASE: r_slow  <= i_cfg_data;
                    slskc_pkg::CFG_MAKEUP:       r_mkp   <= i_cfg_data;
                    slskc_pkg::CFG_MODE:         r_mode  <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
            r_env <= n_env;
            if (op == slskc_pkg::OP_GFIN && n_red > r_peak) r_peak <= n_red;
            if (op == slskc_pkg::OP_MET2) begin
                r_sm   <= met_sum[29:16];
                r_peak <= '0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (op)
            slskc_pkg::OP_LOAD: begin
                r_lraw  <= i_left_sample;
                r_rraw  <= i_right_sample;
                r_lmag  <= in_lmag;
                r_rmag  <= in_rmag;
                r_lneg  <= i_left_sample[SB-1];
                r_rneg  <= in_r[SB-1];
                r_mono  <= i_mono;
                r_last  <= i_block_end;
                r_byp   <= r_mode[0];
                r_level <= (in_lmag > in_rmag) ? in_lmag : in_rmag;
            end
            slskc_pkg::OP_ENV: begin
                r_norm <= env_att;
                r_p    <= PW'(SB - 1);
            end
            slskc_pkg::OP_LZ: begin
                if (!r_norm[SB-1] && r_norm != '0) begin
                    r_norm <= r_norm << 1;
                    r_p    <= r_p - PW'(1);
                end
            end
            slskc_pkg::OP_DB: begin
                r_def  <= (db_l2 >= db_full) ? '0 : db_full - db_l2;
                r_zero <= r_norm == '0;
            end
            slskc_pkg::OP_MAG: begin
                r_x <= 17'(0) - mag_c;
            end
            slskc_pkg::OP_GC1: begin
                r_slope <= slope_now;
                if ((r_knee == '0) ? (x18 > t18) : (xs >= ke)) begin
                    r_gsel <= G_HARD;
                    r_gp   <= DW'(xmt[16:0]) * DW'(slope_now);
                end else if (r_knee == '0 || xs <= ks) begin
                    r_gsel <= G_ZERO;
                end else begin
                    r_gsel <= G_SOFT;
                    r_gp   <= DW'(u18[12:0]) * DW'(u18[12:0]);
                end
            end
            slskc_pkg::OP_GC2: begin
                if (r_gsel == G_SOFT) r_gp <= DW'(r_gp[25:0]) * DW'(r_slope);
            end
            slskc_pkg::OP_GFIN: begin
                r_red <= n_red;
            end
            slskc_pkg::OP_EXP0: begin
                r_n   <= e_prod[27:24];
                r_top <= e_prod[23 -: LB];
                r_g   <= 31'(1) << 30;
                r_j   <= '0;
            end
            slskc_pkg::OP_EXPI: begin
                if (r_top[LB-1]) r_g <= g_prod[60:30];
                r_top <= r_top << 1;
                r_j   <= r_j + JW'(1);
            end
            slskc_pkg::OP_GQ: begin
                r_gq <= g_rnd[30:14];
            end
            slskc_pkg::OP_COMB: begin
                r_comb <= slskc_pkg::COMB_W'(r_gq) * slskc_pkg::COMB_W'(r_mkp);
            end
            slskc_pkg::OP_SCL: begin
                r_prod <= PROD_W'(r_lmag) * PROD_W'(r_comb);
            end
            slskc_pkg::OP_SCR: begin
                r_lo   <= sat_round(r_prod, r_lneg);
                r_prod <= PROD_W'(r_rmag) * PROD_W'(r_comb);
            end
            slskc_pkg::OP_SATR: begin
                r_ro <= sat_round(r_prod, r_rneg);
            end
            slskc_pkg::OP_MET1: begin
                r_macc <= 30'(r_sm) * 30'(slskc_pkg::METER_KEEP);
            end
            slskc_pkg::OP_OUT: begin
                if (i_cmd.out_take) begin
                    r_out_l   <= r_byp ? r_lraw : r_lo;
                    r_out_r   <= r_mono ? '0 : (r_byp ? r_rraw : r_ro);
                    r_out_red <= r_byp ? '0 : r_red;
                    r_out_met <= r_sm;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_st.bypass   = r_mode[0];
    assign o_st.last     = r_last;
    assign o_st.lz_done  = r_norm[SB-1] || (r_norm == '0);
    assign o_st.div_busy = div_busy;
    assign o_st.soft_mid = r_gsel == G_SOFT;
    assign o_st.exp_last = r_j == JW'(LB - 1);

    assign o_left_out     = r_out_l;
    assign o_right_out    = r_out_r;
    assign o_reduction_db = r_out_red;
    assign o_meter_db     = r_out_met;

endmodule

`default_nettype wire

// ===== rtl/stereo_linked_soft_knee_compressor_core.sv =====
`default_nettype none

// The time from input transaction to result is set by the leading-one scan (one bit a
// cycle), the slope division and one exponent-table product a cycle; a soft-knee sample
// adds the knee division and a block end adds the meter update. Bypass goes from the load
// straight to the output step. One transaction is in work at a time; a result waiting in the
// output register does not stop the next input transaction from being accepted.
// Synchronous active-low reset clears the envelope, meter and config registers to defaults.
module stereo_linked_soft_knee_compressor_core #(
    parameter int SAMPLE_BITS    = slskc_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_BITS = slskc_pkg::LOG_TABLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [slskc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [slskc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_right_sample,
    input  wire logic                            i_mono,
    input  wire logic                            i_block_end,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [SAMPLE_BITS-1:0]        o_left_out,
    output logic signed [SAMPLE_BITS-1:0]        o_right_out,
    output logic [slskc_pkg::RED_W-1:0]          o_reduction_db,
    output logic [slskc_pkg::RED_W-1:0]          o_meter_db
);

    slskc_pkg::t_cmd    cmd;
    slskc_pkg::t_status st;

    slskc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    slskc_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_mono         (i_mono),
        .i_block_end    (i_block_end),
        .i_cmd          (cmd),
        .o_st           (st),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_reduction_db (o_reduction_db),
        .o_meter_db     (o_meter_db)
    );

endmodule

`default_nettype wire

// ===== sim/tb_stereo_linked_soft_knee_compressor_checker.sv =====
`default_nettype none

module tb_stereo_linked_soft_knee_compressor_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [slskc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [slskc_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_ready,
    input  wire logic signed [23:0]                  i_left_sample,
    input  wire logic signed [23:0]                  i_right_sample,
    input  wire logic                                i_mono,
    input  wire logic                                i_block_end,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_ready,
    input  wire logic signed [23:0]                  i_left_out,
    input  wire logic signed [23:0]                  i_right_out,
    input  wire logic [slskc_pkg::RED_W-1:0]         i_reduction_db,
    input  wire logic [slskc_pkg::RED_W-1:0]         i_meter_db,
    output int                                       o_errors,
    output int                                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = 24;
    localparam int LB = 8;
    localparam longint FULL = 64'd1 << (SB - 1);

    typedef struct packed {
        logic [23:0]                 left;
        logic [23:0]                 right;
        logic [slskc_pkg::RED_W-1:0] red;
        logic [slskc_pkg::RED_W-1:0] meter;
    } t_frame;

    t_frame expected_frames[$];
    int unsigned log_lut[1 << LB];
    longint unsigned root_lut[16];

    logic [14:0] thr;
    logic [12:0] ratio;
    logic [11:0] knee;
    logic [15:0] att, rel, slow_rel, makeup;
    logic [1:0]  mode;
    longint unsigned env, blk_peak, meter;

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v, r, b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    initial begin
        longint unsigned m;
        int unsigned r;
        for (int i = 0; i < (1 << LB); i++) begin
            m = longint'((1 << LB) + i) << (30 - LB);
            r = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                r <<= 1;
                if (m >= (64'd1 << 31)) begin
                    r |= 1;
                    m >>= 1;
                end
            end
            log_lut[i] = r;
        end
        root_lut[0] = int_sqrt(64'd1 << 59);
        for (int k = 1; k < 16; k++) root_lut[k] = int_sqrt(root_lut[k-1] << 30);
    end

    function automatic longint signed env_to_db(input longint unsigned e);
        int p;
        longint unsigned idx, l2, def, mag;
        if (e == 0) return -32768;
        p = 0;
        while (p < 63 && (e >> (p + 1)) != 0) p++;
        if (p >= LB) idx = (e >> (p - LB)) & ((1 << LB) - 1);
        else idx = (e << (LB - p)) & ((1 << LB) - 1);
        l2 = (longint'(p) << 16) + log_lut[idx];
        def = longint'(SB - 1) << 16;
        def = (l2 >= def) ? 0 : def - l2;
        mag = (def * 394566) >> 24;
        if (mag > 32768) mag = 32768;
        return -longint'(mag);
    endfunction

    function automatic longint unsigned knee_reduction(input longint signed x);
        longint signed t, w, xs, ks, ke;
        longint unsigned r, slope, red, u;
        t = longint'($signed(thr));
        r = ratio;
        w = knee;
        red = 0;
        if (r < 256) r = 256;
        slope = 65536 - (16777216 / r);
        if (w == 0) begin
            if (x > t) red = ($unsigned(x - t) * slope) >> 16;
        end else begin
            xs = 2 * x;
            ks = 2 * t - w;
            ke = 2 * t + w;
            if (xs <= ks) red = 0;
            else if (xs >= ke) red = ($unsigned(x - t) * slope) >> 16;
            else begin
                u = xs - ks;
                red = (u * u * slope) / ($unsigned(w) << 19);
            end
        end
        return red > slskc_pkg::RED_MAX ? slskc_pkg::RED_MAX : red;
    endfunction

    function automatic longint unsigned reduction_to_gain(input longint unsigned red);
        longint unsigned e, n, top, g;
        e = (red * 10885) >> 8;
        n = e >> 16;
        top = (e & 16'hFFFF) >> (16 - LB);
        g = 64'd1 << 30;
        for (int j = 0; j < LB; j++)
            if ((top >> (LB - 1 - j)) & 1) g = (g * root_lut[j] + (64'd1 << 29)) >> 30;
        g = (n > 31) ? 0 : (g >> n);
        return (g + (64'd1 << 13)) >> 14;
    endfunction

    function automatic logic [23:0] apply_gain(input longint signed s,
                                               input longint unsigned comb);
        longint unsigned mag, y;
        mag = s < 0 ? -s : s;
        y = (mag * comb + (64'd1 << 27)) >> 28;
        if (s < 0) begin
            if (y > FULL) y = FULL;
            return 24'(-longint'(y));
        end
        if (y > FULL - 1) y = FULL - 1;
        return 24'(y);
    endfunction

    function automatic t_frame compress_pair(input logic [23:0] li, input logic [23:0] ri,
                                             input logic mono_i, input logic last_i);
        t_frame f;
        longint signed l, r;
        longint unsigned lm, rm, level, red, comb, dmag, fmag, stp;
        logic dpos, fpos;
        l = longint'($signed(li));
        r = mono_i ? l : longint'($signed(ri));
        if (mode[0]) begin
            f.left = li;
            f.right = mono_i ? '0 : ri;
            f.red = '0;
            f.meter = slskc_pkg::RED_W'(meter);
            return f;
        end
        lm = l < 0 ? -l : l;
        rm = r < 0 ? -r : r;
        level = lm > rm ? lm : rm;
        if (level > env) env += (longint'(att) * (level - env)) >> 16;
        else env -= (longint'(rel) * (env - level)) >> 16;
        red = knee_reduction(env_to_db(env));
        if (mode[1] && red > slskc_pkg::AUTO_REL_MIN) begin
            dpos = slow_rel >= rel;
            dmag = dpos ? slow_rel - rel : rel - slow_rel;
            fpos = level >= env;
            fmag = fpos ? level - env : env - level;
            stp = (dmag * fmag) >> 17;
            if (dpos == fpos) begin
                env += stp;
                if (env > FULL) env = FULL;
            end else begin
                env = (stp > env) ? 0 : env - stp;
            end
        end
        comb = reduction_to_gain(red) * makeup;
        f.left = apply_gain(l, comb);
        f.right = mono_i ? '0 : apply_gain(r, comb);
        f.red = slskc_pkg::RED_W'(red);
        if (red > blk_peak) blk_peak = red;
        if (last_i) begin
            meter = (meter * 58982 + blk_peak * 6554 + 32768) >> 16;
            blk_peak = 0;
        end
        f.meter = slskc_pkg::RED_W'(meter);
        return f;
    endfunction

    assign o_pending = expected_frames.size();

    always @(posedge i_clk) begin
        t_frame got, want;
        if (!i_rst_n) begin
            thr <= slskc_pkg::THRESHOLD_RST;
            ratio <= slskc_pkg::RATIO_RST;
            knee <= slskc_pkg::KNEE_RST;
            att <= slskc_pkg::ATTACK_RST;
            rel <= slskc_pkg::RELEASE_RST;
            slow_rel <= slskc_pkg::SLOW_REL_RST;
            makeup <= slskc_pkg::MAKEUP_RST;
            mode <= slskc_pkg::MODE_RST;
            env = 0;
            blk_peak = 0;
            meter = 0;
            expected_frames.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (slskc_pkg::t_cfg_idx'(i_cfg_idx))
                    slskc_pkg::CFG_THRESHOLD:    thr <= i_cfg_data[14:0];
                    slskc_pkg::CFG_RATIO:        ratio <= i_cfg_data[12:0];
                    slskc_pkg::CFG_KNEE:         knee <= i_cfg_data[11:0];
                    slskc_pkg::CFG_ATTACK:       att <= i_cfg_data;
                    slskc_pkg::CFG_RELEASE:      rel <= i_cfg_data;
                    slskc_pkg::CFG_SLOW_RELEASE: slow_rel <= i_cfg_data;
                    slskc_pkg::CFG_MAKEUP:       makeup <= i_cfg_data;
                    slskc_pkg::CFG_MODE:         mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_frames.push_back(compress_pair(i_left_sample, i_right_sample,
                                                        i_mono, i_block_end));
            if (i_out_valid && i_out_ready) begin
                got = {i_left_out, i_right_out, i_reduction_db, i_meter_db};
                if (expected_frames.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("Unexpected result transaction: %h", got);
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("Mismatch: L %h/%h R %h/%h red %0d/%0d meter %0d/%0d",
                                     want.left, got.left, want.right, got.right,
                                     want.red, got.red, want.meter, got.meter);
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

// ===== sim/tb_stereo_linked_soft_knee_compressor_core.sv =====
`default_nettype none

module tb_stereo_linked_soft_knee_compressor_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [slskc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [slskc_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [23:0] i_left_sample = '0;
    logic signed [23:0] i_right_sample = '0;
    logic i_mono = 1'b0;
    logic i_block_end = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [23:0] o_left_out, o_right_out;
    logic [slskc_pkg::RED_W-1:0] o_reduction_db, o_meter_db;
    int errors, pending, idle_cycles;
    bit sink_on = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    stereo_linked_soft_knee_compressor_core dut (.*);

    tb_stereo_linked_soft_knee_compressor_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_left_sample, .i_right_sample, .i_mono, .i_block_end,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_left_out(o_left_out), .i_right_out(o_right_out),
        .i_reduction_db(o_reduction_db), .i_meter_db(o_meter_db),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver stalls at random, with a stall density that is redrawn at random moments.
    always @(posedge i_clk) begin
        int stall_pct;
        if ($urandom_range(0, 299) == 0) stall_pct = $urandom_range(0, 3) * 25;
        i_ready <= sink_on && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAIL stereo_linked_soft_knee_compressor_core");
            $finish;
        end
    end

    task automatic write_reg(input slskc_pkg::t_cfg_idx idx,
                             input logic [slskc_pkg::CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [23:0] l, input logic [23:0] r,
                             input logic mono, input logic last);
        i_valid <= 1'b1;
        i_left_sample <= l;
        i_right_sample <= r;
        i_mono <= mono;
        i_block_end <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic gap();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample(input int amp_sel);
        logic [23:0] v;
        v = $urandom;
        case (amp_sel)
            0: v = $signed(v) >>> $urandom_range(4, 20);
            1: v = $signed(v) >>> $urandom_range(0, 3);
            2: v = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_phase(input int count);
        int burst, amp;
        burst = 0;
        amp = $urandom_range(0, 3);
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                gap();
                burst = $urandom_range(1, 30);
                amp = $urandom_range(0, 3);
            end
            send_pair(rand_sample(amp), rand_sample(amp), $urandom_range(0, 7) == 0,
                      $urandom_range(0, 7) == 0);
            burst--;
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1'b1;
        @(posedge i_clk);

        send_pair(24'h000000, 24'h000000, 1'b0, 1'b0);
        send_pair(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
        send_pair(24'h800000, 24'h7FFFFF, 1'b0, 1'b1);
        send_pair(24'h800000, 24'h123456, 1'b1, 1'b0);
        send_pair(24'h000001, 24'hFFFFFF, 1'b0, 1'b1);
        send_pair(24'h400000, 24'hC00000, 1'b0, 1'b1);
        i_valid <= 1'b0;
        drain();

        write_reg(slskc_pkg::CFG_THRESHOLD, 16'h4000);
        write_reg(slskc_pkg::CFG_RATIO, 16'd5120);
        write_reg(slskc_pkg::CFG_KNEE, 16'd3072);
        write_reg(slskc_pkg::CFG_ATTACK, 16'hFFFF);
        write_reg(slskc_pkg::CFG_RELEASE, 16'd0);
        write_reg(slskc_pkg::CFG_SLOW_RELEASE, 16'hFFFF);
        write_reg(slskc_pkg::CFG_MAKEUP, 16'd64924);
        write_reg(slskc_pkg::CFG_MODE, 16'd2);
        send_pair(24'h7FFFFF, 24'h000000, 1'b0, 1'b0);
        send_pair(24'h100000, 24'h000000, 1'b0, 1'b1);
        send_pair(24'h000010, 24'h800000, 1'b0, 1'b1);
        send_pair(24'h000000, 24'h000000, 1'b0, 1'b1);
        i_valid <= 1'b0;
        drain();

        write_reg(slskc_pkg::CFG_THRESHOLD, 16'd0);
        write_reg(slskc_pkg::CFG_RATIO, 16'd100);
        write_reg(slskc_pkg::CFG_KNEE, 16'd0);
        write_reg(slskc_pkg::CFG_RELEASE, 16'hFFFF);
        write_reg(slskc_pkg::CFG_SLOW_RELEASE, 16'd0);
        write_reg(slskc_pkg::CFG_MODE, 16'd3);
        send_pair(24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
        send_pair(24'h555555, 24'hAAAAAA, 1'b1, 1'b0);
        i_valid <= 1'b0;
        drain();
        write_reg(slskc_pkg::CFG_MODE, 16'd0);
        random_phase(150);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(slskc_pkg::CFG_THRESHOLD,
                      16'(-$signed(16'($urandom_range(0, 15360)))));
            write_reg(slskc_pkg::CFG_RATIO, 16'($urandom_range(200, 5120)));
            write_reg(slskc_pkg::CFG_KNEE,
                      $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 3072)));
            write_reg(slskc_pkg::CFG_ATTACK, 16'($urandom));
            write_reg(slskc_pkg::CFG_RELEASE, 16'($urandom));
            write_reg(slskc_pkg::CFG_SLOW_RELEASE, 16'($urandom));
            write_reg(slskc_pkg::CFG_MAKEUP, 16'($urandom_range(4096, 64924)));
            write_reg(slskc_pkg::CFG_MODE, 16'(phase == 3 ? 1 : $urandom_range(0, 3)));
            random_phase(150);
            drain();
        end

        sink_on = 1'b0;
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS stereo_linked_soft_knee_compressor_core");
        end else begin
            $display("FAIL stereo_linked_soft_knee_compressor_core");
        end
        $finish;
    end
endmodule

`default_nettype wire
